>>> rtl/bhl_pkg.sv
// shared constants, types and the crc32c function for the hash lookup core
`default_nettype none
package bhl_pkg;
    localparam int TABLE_SLOTS      = 4096;
    localparam int SLOTS_PER_BUCKET = 4;
    localparam int SLOT_W   = $clog2(TABLE_SLOTS);
    localparam int LANE_W   = $clog2(SLOTS_PER_BUCKET);
    localparam int BUCKETS  = TABLE_SLOTS / SLOTS_PER_BUCKET;
    localparam int BKT_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int BCNT_W   = $clog2(BUCKETS + 1);
    localparam int ROW_W    = SLOTS_PER_BUCKET * 128;
    localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;
    localparam int QDEPTH   = 2;
    localparam int Q_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [63:0] key;
        logic [15:0] id;
        logic [63:0] fallback;
        logic [BKT_W-1:0] bucket;
    } t_req;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_WAIT, S_EVAL, S_OUT
    } t_state;

    // one crc byte step, eight bit shifts
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] r;
        r = c ^ {24'd0, d};
        for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ CRC32C_POLY) : (r >> 1);
        return r;
    endfunction
endpackage
`default_nettype wire

>>> rtl/bhl_ram.sv
// generic single-port ram with registered read
`default_nettype none
module bhl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

>>> rtl/bhl_front.sv
// front end: accepts requests, hashes the key in two halves, queues them
`default_nettype none
module bhl_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [143:0]   i_data,
    output logic                o_qvalid,
    input  wire logic           i_qpop,
    output bhl_pkg::t_req       o_qreq
);
    import bhl_pkg::*;
    logic        r_s1_v;
    logic [31:0] r_s1_crc;
    logic [63:0] r_s1_key, r_s1_fb;
    logic [15:0] r_s1_id;
    t_req        r_q [QDEPTH];
    logic [Q_W-1:0]    r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic [31:0] crc_lo, crc_hi;
    logic [SLOT_W-1:0] slot;
    logic        push;

    always_comb begin
        crc_lo = 32'd0;
        for (int b = 0; b < 4; b++) crc_lo = crc_byte(crc_lo, i_data[8*b +: 8]);
        crc_hi = r_s1_crc;
        for (int b = 4; b < 8; b++) crc_hi = crc_byte(crc_hi, r_s1_key[8*b +: 8]);
        slot = crc_hi[SLOT_W-1:0];
    end

    // stage 1 may only hand on when the queue has room
    assign push    = r_s1_v && (r_cnt < QCNT_W'(QDEPTH));
    assign o_ready = !r_s1_v || push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0; r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (o_ready) r_s1_v <= i_valid;
            if (push) r_wp <= r_wp + 1'b1;
            if (i_qpop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + QCNT_W'(push) - QCNT_W'(i_qpop);
        end
        if (o_ready && i_valid) begin
            r_s1_key <= i_data[63:0];
            r_s1_id  <= i_data[79:64];
            r_s1_fb  <= i_data[143:80];
            r_s1_crc <= crc_lo;
        end
        if (push) r_q[r_wp] <= '{key: r_s1_key, id: r_s1_id, fallback: r_s1_fb,
                                 bucket: BKT_W'(slot >> LANE_W)};
    end

    assign o_qvalid = (r_cnt != '0);
    assign o_qreq   = r_q[r_rp];
endmodule
`default_nettype wire

>>> rtl/bhl_back.sv
// back end: table clear after reset, bucket probe, update and result register
`default_nettype none
module bhl_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_qvalid,
    output logic               o_qpop,
    input  bhl_pkg::t_req      i_qreq,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [87:0]        o_data
);
    import bhl_pkg::*;
    t_state r_state, n_state;
    t_req   r_req;
    logic [BKT_W-1:0]  r_bkt, n_bkt;
    logic [BCNT_W-1:0] r_cnt, n_cnt;
    logic [63:0] r_val, n_val;
    logic [2:0]  r_flags, n_flags;   // hit, inserted, full
    logic        we;
    logic [BKT_W-1:0] addr;
    logic [ROW_W-1:0] wdata, rdata;
    logic        found;
    logic [LANE_W-1:0] lane;
    logic        lane_hit;
    logic [63:0] k, v;

    bhl_ram #(.WIDTH(ROW_W), .DEPTH(BUCKETS)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wdata), .o_rdata(rdata));

    // first slot of the bucket that matches or is empty
    always_comb begin
        found = 1'b0; lane = '0; lane_hit = 1'b0;
        for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
            k = rdata[s*128 +: 64];
            if (k == r_req.key || k == 64'd0) begin
                found = 1'b1; lane = LANE_W'(s); lane_hit = (k == r_req.key);
            end
        end
        v = rdata[32'(lane)*128 + 64 +: 64];
    end

    always_comb begin
        n_state = r_state; n_bkt = r_bkt; n_cnt = r_cnt; n_val = r_val;
        n_flags = r_flags; we = 1'b0; addr = r_bkt; wdata = rdata; o_qpop = 1'b0;
        case (r_state)
            S_CLEAR: begin
                we = 1'b1; wdata = '0; n_bkt = r_bkt + 1'b1;
                if (r_bkt == BKT_W'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_qvalid) begin
                    o_qpop = 1'b1; n_bkt = i_qreq.bucket; n_cnt = '0;
                    n_val = i_qreq.fallback; n_flags = 3'b000;
                    n_state = (i_qreq.key == 64'd0) ? S_OUT : S_READ;
                end
            end
            S_READ:  n_state = S_WAIT;
            S_WAIT:  n_state = S_EVAL;
            S_EVAL: begin
                if (found) begin
                    if (lane_hit && v != 64'd0) begin
                        n_val = v; n_flags = 3'b001;
                    end else begin
                        we = 1'b1;
                        wdata[32'(lane)*128 +: 128] = {r_req.fallback, r_req.key};
                        n_flags = 3'b010;
                    end
                    n_state = S_OUT;
                end else if (r_cnt == BCNT_W'(BUCKETS - 1)) begin
                    n_flags = 3'b100; n_state = S_OUT;
                end else begin
                    n_bkt = (r_bkt == BKT_W'(BUCKETS - 1)) ? '0 : r_bkt + 1'b1;
                    n_cnt = r_cnt + 1'b1; n_state = S_READ;
                end
            end
            S_OUT: if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_bkt <= '0;
        end else begin
            r_state <= n_state; r_bkt <= n_bkt;
        end
        r_cnt <= n_cnt; r_val <= n_val; r_flags <= n_flags;
        if (o_qpop) r_req <= i_qreq;
    end

    assign o_valid = (r_state == S_OUT);
    assign o_data  = {5'd0, r_flags, r_val, r_req.id};
endmodule
`default_nettype wire

>>> rtl/bucketed_hash_lookup_or_insert_core.sv
// top level of the bucketed hash lookup-or-insert core
//  channel | dir | fields (lsb first)
//  s_axis  | in  | key[63:0], request_id[79:64], fallback_value[143:80]
//  m_axis  | out | result_id[15:0], value[79:16], hit, inserted, table_full
// the back end takes one item at a time: it pops it in S_IDLE, reads a bucket through S_READ
// and S_WAIT, decides in S_EVAL and goes back to S_READ for the next bucket if undecided and buckets remain.
// hashing runs ahead in the front and a two-entry queue lets the front take items while the back probes.
// after reset the table is cleared one bucket a cycle, all 1024 buckets.
// a result waits in its register until m_axis_tready.
`default_nettype none
module bucketed_hash_lookup_or_insert_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [143:0] s_axis_tdata,  // key, request_id, fallback_value
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [87:0]       m_axis_tdata   // result_id, value, hit, inserted, table_full
);
    import bhl_pkg::*;
    logic qvalid, qpop;
    t_req qreq;

    bhl_front u_front (.i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_data(s_axis_tdata), .o_qvalid(qvalid), .i_qpop(qpop), .o_qreq(qreq));
    bhl_back u_back (.i_clk, .i_rst_n, .i_qvalid(qvalid), .o_qpop(qpop), .i_qreq(qreq),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(m_axis_tdata));
endmodule
`default_nettype wire

>>> verif/bhl_checker.sv
// checker for the hash lookup core: shadow table, prediction and result compare
`default_nettype none
module bhl_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_req_valid,
    input  wire logic         i_req_ready,
    input  wire logic [143:0] i_req_data,
    input  wire logic         i_res_valid,
    input  wire logic         i_res_ready,
    input  wire logic [87:0]  i_res_data,
    output int                o_errors,
    output int                o_pending
);
    import bhl_pkg::*;

    typedef struct packed {
        logic [15:0] id;
        logic [63:0] value;
        logic        hit;
        logic        inserted;
        logic        full;
    } t_result;

    logic [63:0] shadow_keys [TABLE_SLOTS];
    logic [63:0] shadow_vals [TABLE_SLOTS];
    t_result     expected_results [$];

    function automatic logic [31:0] key_crc(input logic [63:0] key);
        logic [31:0] c;
        c = '0;
        for (int b = 0; b < 8; b++) begin
            c ^= {24'd0, key[8*b +: 8]};
            for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'h82F6_3B78) : (c >> 1);
        end
        return c;
    endfunction

    function automatic t_result lookup_or_insert(input logic [63:0] key,
                                                 input logic [15:0] id,
                                                 input logic [63:0] fb);
        t_result r;
        int      idx;
        bit      done;
        r = '{id: id, value: fb, hit: 1'b0, inserted: 1'b0, full: 1'b0};
        done = 0;
        if (key != 0) begin
            idx = int'(key_crc(key) & (TABLE_SLOTS - 1) & ~(SLOTS_PER_BUCKET - 1));
            for (int n = 0; n < TABLE_SLOTS && !done; n++) begin
                if (shadow_keys[idx] == key) begin
                    if (shadow_vals[idx] != 0) begin
                        r.value = shadow_vals[idx];
                        r.hit = 1'b1;
                    end else begin
                        shadow_vals[idx] = fb;
                        r.inserted = 1'b1;
                    end
                    done = 1;
                end else if (shadow_keys[idx] == 0) begin
                    shadow_keys[idx] = key;
                    shadow_vals[idx] = fb;
                    r.inserted = 1'b1;
                    done = 1;
                end else begin
                    idx = (idx + 1) % TABLE_SLOTS;
                end
            end
            r.full = !done;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            shadow_keys[i] = '0;
            shadow_vals[i] = '0;
        end
    end

    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && i_req_valid && i_req_ready)
            expected_results.push_back(lookup_or_insert(i_req_data[63:0],
                i_req_data[79:64], i_req_data[143:80]));
        if (i_rst_n && i_res_valid && i_res_ready) begin
            got = '{id: i_res_data[15:0], value: i_res_data[79:16], hit: i_res_data[80],
                    inserted: i_res_data[81], full: i_res_data[82]};
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result id", 64'(got.id), '0);
            end else begin
                want = expected_results.pop_front();
                if (got.id != want.id) report_mismatch("result_id", 64'(got.id), 64'(want.id));
                if (got.value != want.value) report_mismatch("value", got.value, want.value);
                if (got.hit != want.hit) report_mismatch("hit", 64'(got.hit), 64'(want.hit));
                if (got.inserted != want.inserted)
                    report_mismatch("inserted", 64'(got.inserted), 64'(want.inserted));
                if (got.full != want.full)
                    report_mismatch("table_full", 64'(got.full), 64'(want.full));
            end
        end
        o_pending <= expected_results.size();
    end
endmodule
`default_nettype wire

>>> verif/tb_top.sv
// testbench top: stimulus, idling and verdict for the hash lookup core
`default_nettype none
module tb_top;
    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic [143:0] s_data = '0;
    logic         m_ready = 1'b0;
    wire          s_ready;
    wire          m_valid;
    wire  [87:0]  m_data;
    int           errors;
    int           pending;
    int           cycles = 0;
    logic [63:0]  used_keys [$];

    always #5 i_clk = ~i_clk;

    bucketed_hash_lookup_or_insert_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data)
    );

    bhl_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(s_valid), .i_req_ready(s_ready), .i_req_data(s_data),
        .i_res_valid(m_valid), .i_res_ready(m_ready), .i_res_data(m_data),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver stall pattern, with a stall-free stretch
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 60000 && cycles < 70000) m_ready <= 1'b1;
        else m_ready <= (cycles % 23 < 5) ? 1'b0 : ($urandom_range(0, 3) != 0);
        if (cycles > 1500000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_item(input logic [63:0] key, input logic [15:0] id,
                             input logic [63:0] fb);
        s_valid <= 1'b1;
        s_data  <= {fb, id, key};
        do @(posedge i_clk); while (!s_ready);
        if (key != 0) used_keys.push_back(key);
    endtask

    task automatic idle_gap(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    initial begin
        logic [63:0] k;
        int          burst;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: key zero, extremes, zero-valued entries, hits
        send_item(64'd0, 16'h0000, 64'h1234);
        send_item(64'd0, 16'hFFFF, '1);
        send_item('1, 16'hFFFF, '1);
        send_item('1, 16'h0001, 64'd5);
        send_item(64'd1, 16'h0002, 64'd0);
        send_item(64'd1, 16'h0003, 64'd77);
        send_item(64'd1, 16'h0004, 64'd99);
        send_item(64'h8000_0000_0000_0000, 16'h8000, 64'h8000_0000_0000_0000);
        send_item(64'h8000_0000_0000_0000, 16'h7FFF, 64'd1);
        // keys 0x55AA0000 + i, each sent twice: the first round inserts, the second hits
        for (int i = 0; i < 8; i++) send_item(64'h55AA_0000 + i, 16'(i), 64'(i + 1));
        for (int i = 0; i < 8; i++) send_item(64'h55AA_0000 + i, 16'(100 + i), '1);
        idle_gap(2);
        // pause until every result is back
        while (pending != 0) @(posedge i_clk);
        // random part: repeats for half the items, fresh keys for most of the rest, a few zero and small keys
        for (int n = 0; n < 1800; ) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst && n < 1800; b++, n++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: k = rand64();
                    4, 5, 6, 7, 8: k = used_keys.size() ? used_keys[$urandom_range(0,
                                       used_keys.size() - 1)] : rand64();
                    default: k = ($urandom_range(0, 1)) ? 64'd0 : 64'($urandom_range(1, 255));
                endcase
                send_item(k, 16'($urandom()), ($urandom_range(0, 7) == 0) ? 64'd0 : rand64());
            end
            idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 12));
        end
        idle_gap(2);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
